@@ src/tether_constraint_projector_defines.svh @@
// Assertion macros for the tether constraint projector.
`ifndef TETHER_CONSTRAINT_PROJECTOR_DEFINES_SVH
`define TETHER_CONSTRAINT_PROJECTOR_DEFINES_SVH

`define TCP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("tcp assertion failed");

`define TCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcp assertion failed");

`endif

@@ src/tcp_pkg.sv @@
// Shared types and constants of the tether constraint projector.
package tcp_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MOD_START,
        OP_MOD_TAKE,
        OP_LOAD,
        OP_RD_VERTEX,
        OP_RD_ROOT,
        OP_DIFF,
        OP_SQ,
        OP_SQ_FIN,
        OP_SQRT_START,
        OP_SQRT_TAKE,
        OP_RATIO_START,
        OP_RATIO_TAKE,
        OP_LIM_MUL,
        OP_FADE_START,
        OP_FADE_TAKE,
        OP_S_MUL,
        OP_S_TAKE,
        OP_M_MUL,
        OP_M_TAKE,
        OP_A_MUL,
        OP_A_DIV,
        OP_A_TAKE,
        OP_V_MUL,
        OP_AXIS_FIN,
        OP_WRITE_BACK,
        OP_PASS
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic kind;
        logic skip;
        logic dist_zero;
        logic in_band;
        logic s_zero;
    } dp_stat_t;

endpackage

@@ src/tcp_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module tcp_div
    import tcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[63]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (&cnt_reg) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[62:0], fits};
            rem_reg <= fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ src/tcp_sqrt.sv @@
// Integer square root, one result bit per cycle, 64-bit radicand.
module tcp_sqrt
    import tcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && bit_reg[0]) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

@@ src/tcp_datapath.sv @@
// Datapath: position memories, configuration registers, shared multiplier and arithmetic units.
module tcp_datapath
    import tcp_pkg::*;
#(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_kind,
    input  logic [9:0]              s_vertex_index,
    input  logic [9:0]              s_root_index,
    input  logic signed [31:0]      s_pos_x,
    input  logic signed [31:0]      s_pos_y,
    input  logic signed [31:0]      s_pos_z,
    input  logic [30:0]             s_rest_length,
    input  logic                    s_movable,
    output logic signed [31:0]      m_new_x,
    output logic signed [31:0]      m_new_y,
    output logic signed [31:0]      m_new_z,
    output logic signed [31:0]      m_vel_dx,
    output logic signed [31:0]      m_vel_dy,
    output logic signed [31:0]      m_vel_dz,
    output logic                    m_corrected
);

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [31:0] WIDTH_Q16 = 32'd19661;
    localparam logic [31:0] ATTEN_Q16 = 32'd45875;
    localparam logic [31:0] FADE_RECIP = 32'((64'd1 << 46) / 64'(WIDTH_Q16) + 64'd1);
    localparam logic [20:0] MOD_RECIP =
        21'(((64'd1 << 20) + 64'(VERTEX_DEPTH) - 64'd1) / 64'(VERTEX_DEPTH));
    localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSION = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_STRETCH     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE      = CFG_INDEX_W'(3);
    localparam logic signed [33:0] SAT_MAX = 34'sh0_7fff_ffff;
    localparam logic signed [33:0] SAT_MIN = 34'sh3_8000_0000;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7fff_ffff;
        end else if (v < SAT_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    logic [16:0] stiffness_reg;
    logic [16:0] compression_reg;
    logic [19:0] stretch_reg;
    logic [10:0] active_reg;

    logic               kind_reg;
    logic [9:0]         vidx_reg;
    logic [9:0]         ridx_reg;
    logic signed [31:0] pin_reg [3];
    logic [30:0]        rest_reg;
    logic               movable_reg;
    logic [AW-1:0]      vaddr_reg;

    logic signed [31:0] pos_x_mem_reg [VERTEX_DEPTH];
    logic signed [31:0] pos_y_mem_reg [VERTEX_DEPTH];
    logic signed [31:0] pos_z_mem_reg [VERTEX_DEPTH];
    logic signed [31:0] rd_reg [3];

    logic signed [31:0] p_reg [3];
    logic [31:0]        dmag_reg [3];
    logic               dneg_reg [3];
    logic [63:0]        sum_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        distq_reg;
    logic [20:0]        limit_reg;
    logic [31:0]        excess_reg;
    logic               dist_neg_reg;
    logic [31:0]        dist_mag_reg;
    logic [16:0]        fade_reg;
    logic [16:0]        s_reg;
    logic [31:0]        m_reg;
    logic [31:0]        a_reg;
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] out_new_reg [3];
    logic signed [31:0] out_vel_reg [3];
    logic               out_corr_reg;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod_next;
    logic               div_start;
    logic [63:0]        div_dividend;
    logic [31:0]        div_divisor;
    logic               div_busy;
    logic [63:0]        div_quo;
    logic               sqrt_busy;
    logic [31:0]        sqrt_root;

    logic [30:0]        mod_prod;
    logic [10:0]        mod_q;
    logic [31:0]        mod_rem;

    logic               mem_we;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] d_sat [3];
    logic [31:0]        d_mag [3];
    logic signed [33:0] d_wide;
    logic signed [32:0] d_ext;
    logic [16:0]        stiff_c;
    logic [16:0]        climit;
    logic [20:0]        slimit;
    logic [31:0]        ratio_sat;
    logic               comp;
    logic               strch;
    logic signed [48:0] dist_full;
    logic               fin_neg;
    logic signed [33:0] add_mag;
    logic signed [33:0] vel_mag;
    logic signed [33:0] new_wide;
    logic signed [33:0] vel_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiffness_reg   <= '0;
            compression_reg <= '0;
            stretch_reg     <= '0;
            active_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STIFFNESS:   stiffness_reg   <= cfg_data[16:0];
                REG_COMPRESSION: compression_reg <= cfg_data[16:0];
                REG_STRETCH:     stretch_reg     <= cfg_data[19:0];
                REG_ACTIVE:      active_reg      <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    tcp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo)
    );

    tcp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_SQRT_START),
        .radicand (sum_reg),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ: begin
                mul_a = dmag_reg[cmd.axis];
                mul_b = dmag_reg[cmd.axis];
            end
            OP_LIM_MUL: begin
                mul_a = 32'(limit_reg);
                mul_b = 32'(rest_reg);
            end
            OP_FADE_START: begin
                mul_a = 32'(excess_reg[14:0]);
                mul_b = FADE_RECIP;
            end
            OP_S_MUL: begin
                mul_a = 32'(stiff_c);
                mul_b = 32'(fade_reg);
            end
            OP_M_MUL: begin
                mul_a = dist_mag_reg;
                mul_b = 32'(s_reg);
            end
            OP_A_MUL: begin
                mul_a = dmag_reg[cmd.axis];
                mul_b = m_reg;
            end
            OP_V_MUL: begin
                mul_a = a_reg;
                mul_b = ATTEN_Q16;
            end
            default: ;
        endcase
        prod_next = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (cmd.op)
            OP_RATIO_START: begin
                div_start    = 1'b1;
                div_dividend = {16'd0, distq_reg, 16'd0};
                div_divisor  = {1'b0, rest_reg};
            end
            OP_A_DIV: begin
                div_start    = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = distq_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        mod_prod = 31'(vidx_reg) * 31'(MOD_RECIP);
        mod_q    = mod_prod[30:20];
        mod_rem  = 32'(vidx_reg) - 32'(mod_q) * 32'(VERTEX_DEPTH);
    end

    always_comb begin
        d_wide = '0;
        d_ext  = '0;
        for (int k = 0; k < 3; k++) begin
            d_wide   = 34'(rd_reg[k]) - 34'(p_reg[k]);
            d_sat[k] = sat34(d_wide);
            d_ext    = 33'(d_sat[k]);
            d_mag[k] = 32'(d_sat[k][31] ? -d_ext : d_ext);
        end
    end

    always_comb begin
        stiff_c   = (stiffness_reg > ONE_Q16) ? ONE_Q16 : stiffness_reg;
        climit    = ONE_Q16 - ((compression_reg > ONE_Q16) ? ONE_Q16 : compression_reg);
        slimit    = 21'(ONE_Q16) + 21'(stretch_reg);
        ratio_sat = (|div_quo[63:32]) ? 32'hffff_ffff : div_quo[31:0];
        comp      = ratio_sat < 32'(climit);
        strch     = ratio_sat > 32'(slimit);
        dist_full = $signed({17'd0, distq_reg}) - $signed({1'b0, prod_reg[63:16]});
        fin_neg   = dneg_reg[cmd.axis] ^ dist_neg_reg;
        add_mag   = $signed({2'b00, a_reg});
        vel_mag   = $signed({2'b00, prod_reg[47:16]});
        new_wide  = 34'(p_reg[cmd.axis]) + (fin_neg ? -add_mag : add_mag);
        vel_wide  = fin_neg ? -vel_mag : vel_mag;
    end

    assign mem_we  = (cmd.op == OP_LOAD) || (cmd.op == OP_WRITE_BACK);
    assign rd_addr = (cmd.op == OP_RD_ROOT) ? AW'(ridx_reg) : vaddr_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pos_x_mem_reg[vaddr_reg] <= (cmd.op == OP_LOAD) ? pin_reg[0] : p_reg[0];
            pos_y_mem_reg[vaddr_reg] <= (cmd.op == OP_LOAD) ? pin_reg[1] : p_reg[1];
            pos_z_mem_reg[vaddr_reg] <= (cmd.op == OP_LOAD) ? pin_reg[2] : p_reg[2];
        end
        rd_reg[0] <= pos_x_mem_reg[rd_addr];
        rd_reg[1] <= pos_y_mem_reg[rd_addr];
        rd_reg[2] <= pos_z_mem_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                kind_reg    <= s_kind;
                vidx_reg    <= s_vertex_index;
                ridx_reg    <= s_root_index;
                pin_reg[0]  <= s_pos_x;
                pin_reg[1]  <= s_pos_y;
                pin_reg[2]  <= s_pos_z;
                rest_reg    <= s_rest_length;
                movable_reg <= s_movable;
            end
            OP_MOD_TAKE: vaddr_reg <= AW'(mod_rem);
            OP_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    out_new_reg[k] <= pin_reg[k];
                    out_vel_reg[k] <= '0;
                end
                out_corr_reg <= 1'b0;
            end
            OP_RD_ROOT: begin
                for (int k = 0; k < 3; k++) begin
                    p_reg[k] <= rd_reg[k];
                end
            end
            OP_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    dmag_reg[k] <= d_mag[k];
                    dneg_reg[k] <= d_sat[k][31];
                end
                sum_reg  <= '0;
                prod_reg <= '0;
            end
            OP_SQ: begin
                sum_reg  <= sum_reg + prod_reg;
                prod_reg <= prod_next;
            end
            OP_SQ_FIN:    sum_reg <= sum_reg + prod_reg;
            OP_SQRT_TAKE: distq_reg <= sqrt_root;
            OP_RATIO_TAKE: begin
                limit_reg  <= comp ? 21'(climit) : slimit;
                excess_reg <= comp ? 32'(climit) - ratio_sat : ratio_sat - 32'(slimit);
            end
            OP_LIM_MUL: prod_reg <= prod_next;
            OP_FADE_START: begin
                dist_neg_reg <= dist_full[48];
                dist_mag_reg <= 32'(dist_full[48] ? -dist_full : dist_full);
                prod_reg     <= prod_next;
            end
            OP_FADE_TAKE: fade_reg <= (excess_reg >= WIDTH_Q16) ? ONE_Q16 : prod_reg[46:30];
            OP_S_MUL:     prod_reg <= prod_next;
            OP_S_TAKE:    s_reg <= prod_reg[32:16];
            OP_M_MUL:     prod_reg <= prod_next;
            OP_M_TAKE:    m_reg <= prod_reg[47:16];
            OP_A_MUL:     prod_reg <= prod_next;
            OP_A_TAKE:    a_reg <= div_quo[31:0];
            OP_V_MUL:     prod_reg <= prod_next;
            OP_AXIS_FIN: begin
                p_reg[cmd.axis]   <= sat34(new_wide);
                vel_reg[cmd.axis] <= sat34(vel_wide);
            end
            OP_WRITE_BACK: begin
                for (int k = 0; k < 3; k++) begin
                    out_new_reg[k] <= p_reg[k];
                    out_vel_reg[k] <= vel_reg[k];
                end
                out_corr_reg <= 1'b1;
            end
            OP_PASS: begin
                for (int k = 0; k < 3; k++) begin
                    out_new_reg[k] <= p_reg[k];
                    out_vel_reg[k] <= '0;
                end
                out_corr_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        stat.busy      = div_busy | sqrt_busy;
        stat.kind      = kind_reg;
        stat.skip      = (stiffness_reg == '0) || !movable_reg
                         || (32'(ridx_reg) >= 32'(VERTEX_DEPTH))
                         || (11'(ridx_reg) >= active_reg) || (rest_reg == '0);
        stat.dist_zero = (sqrt_root == '0);
        stat.in_band   = !comp && !strch;
        stat.s_zero    = (prod_reg[32:16] == '0);
    end

    assign m_new_x     = out_new_reg[0];
    assign m_new_y     = out_new_reg[1];
    assign m_new_z     = out_new_reg[2];
    assign m_vel_dx    = out_vel_reg[0];
    assign m_vel_dy    = out_vel_reg[1];
    assign m_vel_dz    = out_vel_reg[2];
    assign m_corrected = out_corr_reg;

endmodule

@@ src/tcp_ctrl.sv @@
// Controller: sequences one transaction through the datapath and drives the handshakes.
module tcp_ctrl
    import tcp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE, S_MOD_START, S_MOD_WAIT, S_MOD_TAKE, S_LOAD, S_RD_VERTEX, S_RD_ROOT,
        S_DIFF, S_SQ, S_SQ_FIN, S_SQRT_START, S_SQRT_WAIT, S_SQRT_TAKE,
        S_RATIO_START, S_RATIO_WAIT, S_RATIO_TAKE, S_LIM_MUL, S_FADE_START,
        S_FADE_WAIT, S_FADE_TAKE, S_S_MUL, S_S_TAKE, S_M_MUL, S_M_TAKE,
        S_A_MUL, S_A_DIV, S_A_WAIT, S_A_TAKE, S_V_MUL, S_AXIS_FIN,
        S_WRITE_BACK, S_PASS, S_OUT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] axis_reg;
    logic [1:0] axis_next;
    logic       s_ready_reg;
    logic       m_valid_reg;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE:        if (s_valid) state_next = S_MOD_START;
            S_MOD_START:   state_next = S_MOD_WAIT;
            S_MOD_WAIT:    if (!stat.busy) state_next = S_MOD_TAKE;
            S_MOD_TAKE:    state_next = stat.kind ? S_RD_VERTEX : S_LOAD;
            S_LOAD:        state_next = S_OUT;
            S_RD_VERTEX:   state_next = S_RD_ROOT;
            S_RD_ROOT:     state_next = stat.skip ? S_PASS : S_DIFF;
            S_DIFF: begin
                state_next = S_SQ;
                axis_next  = 2'd0;
            end
            S_SQ: begin
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2) state_next = S_SQ_FIN;
            end
            S_SQ_FIN:      state_next = S_SQRT_START;
            S_SQRT_START:  state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:   if (!stat.busy) state_next = S_SQRT_TAKE;
            S_SQRT_TAKE:   state_next = stat.dist_zero ? S_PASS : S_RATIO_START;
            S_RATIO_START: state_next = S_RATIO_WAIT;
            S_RATIO_WAIT:  if (!stat.busy) state_next = S_RATIO_TAKE;
            S_RATIO_TAKE:  state_next = stat.in_band ? S_PASS : S_LIM_MUL;
            S_LIM_MUL:     state_next = S_FADE_START;
            S_FADE_START:  state_next = S_FADE_WAIT;
            S_FADE_WAIT:   if (!stat.busy) state_next = S_FADE_TAKE;
            S_FADE_TAKE:   state_next = S_S_MUL;
            S_S_MUL:       state_next = S_S_TAKE;
            S_S_TAKE:      state_next = stat.s_zero ? S_PASS : S_M_MUL;
            S_M_MUL:       state_next = S_M_TAKE;
            S_M_TAKE: begin
                state_next = S_A_MUL;
                axis_next  = 2'd0;
            end
            S_A_MUL:       state_next = S_A_DIV;
            S_A_DIV:       state_next = S_A_WAIT;
            S_A_WAIT:      if (!stat.busy) state_next = S_A_TAKE;
            S_A_TAKE:      state_next = S_V_MUL;
            S_V_MUL:       state_next = S_AXIS_FIN;
            S_AXIS_FIN: begin
                axis_next  = axis_reg + 2'd1;
                state_next = (axis_reg == 2'd2) ? S_WRITE_BACK : S_A_MUL;
            end
            S_WRITE_BACK:  state_next = S_OUT;
            S_PASS:        state_next = S_OUT;
            S_OUT:         if (m_ready) state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            axis_reg    <= 2'd0;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            s_ready_reg <= (state_next == S_IDLE);
            m_valid_reg <= (state_next == S_OUT);
        end
    end

    always_comb begin
        cmd.axis = axis_reg;
        unique case (state_reg)
            S_IDLE:        cmd.op = s_valid ? OP_CAPTURE : OP_NONE;
            S_MOD_START:   cmd.op = OP_MOD_START;
            S_MOD_TAKE:    cmd.op = OP_MOD_TAKE;
            S_LOAD:        cmd.op = OP_LOAD;
            S_RD_VERTEX:   cmd.op = OP_RD_VERTEX;
            S_RD_ROOT:     cmd.op = OP_RD_ROOT;
            S_DIFF:        cmd.op = OP_DIFF;
            S_SQ:          cmd.op = OP_SQ;
            S_SQ_FIN:      cmd.op = OP_SQ_FIN;
            S_SQRT_START:  cmd.op = OP_SQRT_START;
            S_SQRT_TAKE:   cmd.op = OP_SQRT_TAKE;
            S_RATIO_START: cmd.op = OP_RATIO_START;
            S_RATIO_TAKE:  cmd.op = OP_RATIO_TAKE;
            S_LIM_MUL:     cmd.op = OP_LIM_MUL;
            S_FADE_START:  cmd.op = OP_FADE_START;
            S_FADE_TAKE:   cmd.op = OP_FADE_TAKE;
            S_S_MUL:       cmd.op = OP_S_MUL;
            S_S_TAKE:      cmd.op = OP_S_TAKE;
            S_M_MUL:       cmd.op = OP_M_MUL;
            S_M_TAKE:      cmd.op = OP_M_TAKE;
            S_A_MUL:       cmd.op = OP_A_MUL;
            S_A_DIV:       cmd.op = OP_A_DIV;
            S_A_TAKE:      cmd.op = OP_A_TAKE;
            S_V_MUL:       cmd.op = OP_V_MUL;
            S_AXIS_FIN:    cmd.op = OP_AXIS_FIN;
            S_WRITE_BACK:  cmd.op = OP_WRITE_BACK;
            S_PASS:        cmd.op = OP_PASS;
            default:       cmd.op = OP_NONE;
        endcase
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

@@ src/tether_constraint_projector.sv @@
// Tether constraint projector top level. Keeps VERTEX_DEPTH vertex positions (signed Q16.16
// per axis) and takes one transaction at a time. A load transaction stores a position and
// presents its result. A project transaction pulls a vertex toward or away from its root
// and writes the result back; a full correction uses the shared one-bit-per-cycle divider
// for the ratio and for one division per axis, and the 32-step square root unit. A
// projection skipped on its inputs, one with zero distance and one inside the limits
// present their result without a correction. A new transaction is accepted in the cycle
// after the result is taken. Configuration writes are accepted every cycle, and are meant
// for idle periods.
`include "tether_constraint_projector_defines.svh"

module tether_constraint_projector
    import tcp_pkg::*;
#(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic [9:0]              s_vertex_index,
    input  logic [9:0]              s_root_index,
    input  logic signed [31:0]      s_pos_x,
    input  logic signed [31:0]      s_pos_y,
    input  logic signed [31:0]      s_pos_z,
    input  logic [30:0]             s_rest_length,
    input  logic                    s_movable,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [31:0]      m_new_x,
    output logic signed [31:0]      m_new_y,
    output logic signed [31:0]      m_new_z,
    output logic signed [31:0]      m_vel_dx,
    output logic signed [31:0]      m_vel_dy,
    output logic signed [31:0]      m_vel_dz,
    output logic                    m_corrected
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    tcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcp_datapath #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_kind         (s_kind),
        .s_vertex_index (s_vertex_index),
        .s_root_index   (s_root_index),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_rest_length  (s_rest_length),
        .s_movable      (s_movable),
        .m_new_x        (m_new_x),
        .m_new_y        (m_new_y),
        .m_new_z        (m_new_z),
        .m_vel_dx       (m_vel_dx),
        .m_vel_dy       (m_vel_dy),
        .m_vel_dz       (m_vel_dz),
        .m_corrected    (m_corrected)
    );

    `TCP_ASSERT_ALWAYS(a_one_side, !(s_ready && m_valid))
    `TCP_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready && !m_valid)
    `TCP_ASSERT_NEXT(a_idle_after_result, m_valid && m_ready, s_ready && !m_valid)
    `TCP_ASSERT_ALWAYS(a_vel_zero_uncorrected,
        !(m_valid && !m_corrected) || (m_vel_dx == 0 && m_vel_dy == 0 && m_vel_dz == 0))

endmodule
